@@ hdl/ssc_pkg.sv @@
`default_nettype none

package ssc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int BAND_W      = 15;
	localparam int ENABLE_W    = 4;
	localparam int COUNT_W     = 32;
	localparam int CROSS_W     = 16;

	// exponential average, Q.8 accumulator
	localparam int ACC_W      = SAMPLE_BITS + 8;
	localparam int EMA_X_W    = ACC_W + 5;
	localparam int EMA_MAG_W  = 28;
	localparam int EMA_PROD_W = 2 * EMA_MAG_W;
	localparam int EMA_SHIFT  = 31;
	localparam int EMA_Q_W    = EMA_PROD_W - EMA_SHIFT;
	// ceil(2^31 / 10), exact floor(x / 10) for x below 2^30
	localparam logic [EMA_MAG_W-1:0] EMA_RECIP = 28'd214748365;

	localparam int QUEUE_DEPTH = 2;

	localparam int EN_FILTER = 0;
	localparam int EN_THRESH = 1;
	localparam int EN_HIGH   = 2;
	localparam int EN_LOW    = 3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CAL_OFFSET = 3'd0,
		REG_CAL_SCALE  = 3'd1,
		REG_HIGH_LIMIT = 3'd2,
		REG_LOW_LIMIT  = 3'd3,
		REG_HYST_BAND  = 3'd4,
		REG_ENABLE     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		sample_t                 cal_offset;
		logic [15:0]             cal_scale;
		sample_t                 high_limit;
		sample_t                 low_limit;
		logic [BAND_W-1:0]       band;
		logic [ENABLE_W-1:0]     enable;
	} cfg_t;

	typedef struct packed {
		sample_t                 calibrated;
		sample_t                 filtered;
		sample_t                 min_val;
		sample_t                 max_val;
		sample_t                 smoothed;
		logic                    high_alarm;
		logic                    low_alarm;
		logic                    threshold_event;
		logic [COUNT_W-1:0]      samples;
		logic [CROSS_W-1:0]      crossings;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/ssc_ram.sv @@
`default_nettype none

module ssc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                             wdata,
	input  wire logic                                         re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hdl/ssc_front.sv @@
`default_nettype none

module ssc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ssc_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ssc_pkg::sample_t raw_sample,
	input  wire logic           q_full,
	output logic                push,
	output ssc_pkg::sample_t    push_data
);

	localparam int SUM_W  = ssc_pkg::SAMPLE_BITS + 1;
	localparam int PROD_W = 2 * SUM_W;

	localparam logic signed [PROD_W-1:0] HI = PROD_W'(ssc_pkg::SAT_MAX);
	localparam logic signed [PROD_W-1:0] LO = PROD_W'(ssc_pkg::SAT_MIN);

	logic                     v_s1, v_s2;
	logic                     load2;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] shifted;

	assign push     = v_s2 && !q_full;
	assign load2    = !v_s2 || push;
	assign in_ready = !v_s1 || load2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (load2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sum_s1 <= SUM_W'(raw_sample) + SUM_W'(cfg.cal_offset);
		if (load2 && v_s1)
			prod_s2 <= sum_s1 * $signed({1'b0, cfg.cal_scale});
	end

	// Q8.8 product back to integer, truncating toward zero, then clamp
	always_comb begin
		if (prod_s2[PROD_W-1])
			shifted = (prod_s2 + PROD_W'(255)) >>> 8;
		else
			shifted = prod_s2 >>> 8;
		priority if (shifted > HI)
			push_data = ssc_pkg::SAT_MAX;
		else if (shifted < LO)
			push_data = ssc_pkg::SAT_MIN;
		else
			push_data = shifted[ssc_pkg::SAMPLE_BITS-1:0];
	end

endmodule

`default_nettype wire

@@ hdl/ssc_queue.sv @@
`default_nettype none

module ssc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ssc_pkg::sample_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output ssc_pkg::sample_t      q_data
);

	localparam int PW = (ssc_pkg::QUEUE_DEPTH > 1) ? $clog2(ssc_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(ssc_pkg::QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(ssc_pkg::QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ssc_pkg::QUEUE_DEPTH);

	ssc_pkg::sample_t entry_q [ssc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == FULL_CNT);
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != FULL_CNT) || pop)
		else $error("queue written while full");
`endif

endmodule

`default_nettype wire

@@ hdl/ssc_div.sv @@
`default_nettype none

// Signed by unsigned restoring divider, two quotient bits per cycle,
// quotient truncated toward zero.
module ssc_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 4,
	parameter int QW    = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic                         done,
	output logic signed [QW-1:0]         quo
);

	localparam int EVEN_W = NUM_W + (NUM_W % 2);
	localparam int STEPS  = EVEN_W / 2;
	localparam int SW     = $clog2(STEPS + 1);
	localparam int RW     = DEN_W + 1;

	logic              busy_q;
	logic [SW-1:0]     cnt_q;
	logic              neg_q;
	logic [EVEN_W-1:0] q_q, q_nx, q_signed;
	logic [RW-1:0]     rem_q, rem_nx;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  mag;

	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_comb begin
		logic [RW-1:0]     r, rs;
		logic [EVEN_W-1:0] q;
		logic              qbit;
		r = rem_q;
		q = q_q;
		for (int i = 0; i < 2; i++) begin
			rs = {r[DEN_W-1:0], q[EVEN_W-1]};
			if (rs >= {1'b0, den_q}) begin
				r    = rs - {1'b0, den_q};
				qbit = 1'b1;
			end else begin
				r    = rs;
				qbit = 1'b0;
			end
			q = {q[EVEN_W-2:0], qbit};
		end
		rem_nx = r;
		q_nx   = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && !start && (cnt_q == SW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= EVEN_W'(mag);
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			q_q   <= q_nx;
			rem_q <= rem_nx;
		end
	end

	assign q_signed = neg_q ? (~q_q + 1'b1) : q_q;
	assign quo      = q_signed[QW-1:0];

endmodule

`default_nettype wire

@@ hdl/ssc_back.sv @@
`default_nettype none

module ssc_back #(
	parameter int FILTER_DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ssc_pkg::cfg_t    cfg,
	input  wire logic             q_valid,
	input  wire ssc_pkg::sample_t q_data,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ssc_pkg::result_t      result
);

	localparam int AW    = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int CW    = $clog2(FILTER_DEPTH + 1);
	localparam int SUM_W = ssc_pkg::SAMPLE_BITS + $clog2(FILTER_DEPTH);
	localparam int LIM_W = ssc_pkg::SAMPLE_BITS + 2;
	localparam int ACC_W = ssc_pkg::ACC_W;
	localparam int X_W   = ssc_pkg::EMA_X_W;
	localparam int MAG_W = ssc_pkg::EMA_MAG_W;

	localparam logic [AW-1:0] LAST_SLOT = AW'(FILTER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(FILTER_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} back_state_t;

	back_state_t state_q;

	ssc_pkg::sample_t cal_q, filt_q, min_q, max_q, min_nx, max_nx;
	logic [ssc_pkg::COUNT_W-1:0] cnt_q;
	logic [ssc_pkg::CROSS_W-1:0] cross_q;
	logic                        high_q, low_q, evt_q;
	logic                        hi_nx, lo_nx, ev_nx;
	logic                        first, filt_en;

	logic [AW-1:0]           slot_q;
	logic [CW-1:0]           fill_q, iss_q;
	logic                    rdv_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ssc_pkg::SAMPLE_BITS-1:0] ram_rd;
	logic                    ram_we, ram_re;

	logic                    div_start, div_done;
	ssc_pkg::sample_t        div_quo;

	logic signed [ACC_W-1:0]           acc_q, acc_upd, acc_rnd;
	logic signed [X_W-1:0]             ema_x;
	logic                              ev_s1, ev_s2, neg_s1, neg_s2;
	logic [MAG_W-1:0]                  mag_s1;
	logic [ssc_pkg::EMA_PROD_W-1:0]    prod_s2;
	logic [ssc_pkg::EMA_Q_W-1:0]       ema_q;

	logic signed [LIM_W-1:0] v_l, hi_up, hi_dn, lo_up, lo_dn;
	logic                    load_out;
	ssc_pkg::sample_t        smooth;

	assign first   = (cnt_q == '0);
	assign filt_en = cfg.enable[ssc_pkg::EN_FILTER];

	ssc_ram #(
		.WIDTH (ssc_pkg::SAMPLE_BITS),
		.DEPTH (FILTER_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (cal_q),
		.re    (ram_re),
		.raddr (iss_q[AW-1:0]),
		.rdata (ram_rd)
	);

	ssc_div #(
		.NUM_W (SUM_W),
		.DEN_W (CW),
		.QW    (ssc_pkg::SAMPLE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (fill_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: pop = q_valid;
			ST_UPD:  ram_we = filt_en;
			ST_SUM: begin
				ram_re    = (iss_q != fill_q);
				div_start = (iss_q == fill_q) && !rdv_q;
			end
			ST_DIV: ;
			ST_FIN:  load_out = !ev_s1 && !ev_s2 && (!out_valid || out_ready);
			default: ;
		endcase
	end

	// min/max and hysteresis alarms
	always_comb begin
		v_l   = LIM_W'(cal_q);
		hi_up = LIM_W'(cfg.high_limit) + LIM_W'(cfg.band);
		hi_dn = LIM_W'(cfg.high_limit) - LIM_W'(cfg.band);
		lo_up = LIM_W'(cfg.low_limit) + LIM_W'(cfg.band);
		lo_dn = LIM_W'(cfg.low_limit) - LIM_W'(cfg.band);

		min_nx = (first || cal_q < min_q) ? cal_q : min_q;
		max_nx = (first || cal_q > max_q) ? cal_q : max_q;

		hi_nx = high_q;
		lo_nx = low_q;
		ev_nx = 1'b0;
		if (cfg.enable[ssc_pkg::EN_THRESH]) begin
			if (cfg.enable[ssc_pkg::EN_HIGH]) begin
				if (v_l > hi_up) begin
					ev_nx = !high_q;
					hi_nx = 1'b1;
				end else if (v_l < hi_dn) begin
					hi_nx = 1'b0;
				end
			end
			if (cfg.enable[ssc_pkg::EN_LOW]) begin
				if (v_l < lo_dn) begin
					ev_nx = ev_nx || !low_q;
					lo_nx = 1'b1;
				end else if (v_l > lo_up) begin
					lo_nx = 1'b0;
				end
			end
		end
	end

	// 9*acc + 256*v, then / 10 through a reciprocal multiply on the magnitude
	assign ema_x   = (X_W'(acc_q) <<< 3) + X_W'(acc_q) + (X_W'(cal_q) <<< 8);
	assign ema_q   = prod_s2[ssc_pkg::EMA_SHIFT +: ssc_pkg::EMA_Q_W];
	assign acc_upd = neg_s2 ? -ACC_W'(ema_q) : ACC_W'(ema_q);
	assign acc_rnd = acc_q[ACC_W-1] ? ((acc_q + ACC_W'(255)) >>> 8) : (acc_q >>> 8);
	assign smooth  = acc_rnd[ssc_pkg::SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cross_q   <= '0;
			min_q     <= '0;
			max_q     <= '0;
			acc_q     <= '0;
			high_q    <= 1'b0;
			low_q     <= 1'b0;
			evt_q     <= 1'b0;
			slot_q    <= '0;
			fill_q    <= '0;
			iss_q     <= '0;
			rdv_q     <= 1'b0;
			ev_s1     <= 1'b0;
			ev_s2     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			ev_s1 <= (state_q == ST_UPD) && !first;
			ev_s2 <= ev_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (pop)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (cnt_q != '1)
						cnt_q <= cnt_q + 1'b1;
					if (ev_nx && cross_q != '1)
						cross_q <= cross_q + 1'b1;
					min_q  <= min_nx;
					max_q  <= max_nx;
					high_q <= hi_nx;
					low_q  <= lo_nx;
					evt_q  <= ev_nx;
					if (first)
						acc_q <= ACC_W'(cal_q) <<< 8;
					if (filt_en) begin
						slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
						if (fill_q != FULL_CNT)
							fill_q <= fill_q + 1'b1;
						iss_q   <= '0;
						rdv_q   <= 1'b0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SUM: begin
					rdv_q <= ram_re;
					if (ram_re)
						iss_q <= iss_q + 1'b1;
					if (div_start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ev_s2)
				acc_q <= acc_upd;
			if (load_out)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cal_q <= q_data;
		if (state_q == ST_UPD) begin
			sum_q  <= '0;
			mag_s1 <= ema_x[X_W-1] ? MAG_W'(-ema_x) : MAG_W'(ema_x);
			neg_s1 <= ema_x[X_W-1];
			if (!filt_en)
				filt_q <= cal_q;
		end
		if (state_q == ST_SUM && rdv_q)
			sum_q <= sum_q + SUM_W'($signed(ram_rd));
		if (state_q == ST_DIV && div_done)
			filt_q <= div_quo;
		if (ev_s1) begin
			prod_s2 <= mag_s1 * ssc_pkg::EMA_RECIP;
			neg_s2  <= neg_s1;
		end
		if (load_out) begin
			result.calibrated      <= cal_q;
			result.filtered        <= filt_q;
			result.min_val         <= min_q;
			result.max_val         <= max_q;
			result.smoothed        <= smooth;
			result.high_alarm      <= high_q;
			result.low_alarm       <= low_q;
			result.threshold_event <= evt_q;
			result.samples         <= cnt_q;
			result.crossings       <= cross_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond window depth");
	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) ##1 (state_q == ST_IDLE) |-> out_valid)
		else $error("item finished without a result");
	a_ema_single: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s1 |=> !ev_s1)
		else $error("average update issued twice in a row");
`endif

endmodule

`default_nettype wire

@@ hdl/sensor_sample_conditioner.sv @@
// Path: a sample passes the front (offset sum, scale product), the queue, and the back states
// IDLE, UPD, SUM (window sum, SW = 16 + clog2(FILTER_DEPTH) bits), DIV and FIN to out_valid;
// with the filter off SUM and DIV are skipped. The back end takes one sample at a time, paced
// by the window sum, the 2-bit/cycle divider and out_ready; front and queue buffer samples.
// Reset: arst_n clears all control state, counters, alarms and the window fill count;
// registers return to their defaults (cal_scale 1.0). Window RAM contents are not cleared.
`default_nettype none

module sensor_sample_conditioner #(
	parameter int FILTER_DEPTH = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [15:0]                  raw_sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [15:0]                       calibrated_value,
	output logic signed [15:0]                       filtered_value,
	output logic signed [15:0]                       min_value,
	output logic signed [15:0]                       max_value,
	output logic signed [15:0]                       smoothed_average,
	output logic                                     high_alarm,
	output logic                                     low_alarm,
	output logic                                     threshold_event,
	output logic [31:0]                              samples_seen,
	output logic [15:0]                              crossings_seen,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ssc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [ssc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	ssc_pkg::cfg_t    cfg_q;
	ssc_pkg::result_t result;
	ssc_pkg::sample_t push_data, q_data;
	logic             push, q_full, pop, q_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_offset <= '0;
			cfg_q.cal_scale  <= 16'd256;
			cfg_q.high_limit <= '0;
			cfg_q.low_limit  <= '0;
			cfg_q.band       <= '0;
			cfg_q.enable     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ssc_pkg::cfg_reg_t'(cfg_index))
				ssc_pkg::REG_CAL_OFFSET: cfg_q.cal_offset <= cfg_data;
				ssc_pkg::REG_CAL_SCALE:  cfg_q.cal_scale  <= cfg_data;
				ssc_pkg::REG_HIGH_LIMIT: cfg_q.high_limit <= cfg_data;
				ssc_pkg::REG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_data;
				ssc_pkg::REG_HYST_BAND:  cfg_q.band       <= cfg_data[ssc_pkg::BAND_W-1:0];
				ssc_pkg::REG_ENABLE:     cfg_q.enable     <= cfg_data[ssc_pkg::ENABLE_W-1:0];
				default: ;
			endcase
		end
	end

	ssc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_sample (raw_sample),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	ssc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	ssc_back #(
		.FILTER_DEPTH (FILTER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign calibrated_value = result.calibrated;
	assign filtered_value   = result.filtered;
	assign min_value        = result.min_val;
	assign max_value        = result.max_val;
	assign smoothed_average = result.smoothed;
	assign high_alarm       = result.high_alarm;
	assign low_alarm        = result.low_alarm;
	assign threshold_event  = result.threshold_event;
	assign samples_seen     = result.samples;
	assign crossings_seen   = result.crossings;

endmodule

`default_nettype wire

@@ tb/sensor_sample_conditioner_test.sv @@
`default_nettype none

module sensor_sample_conditioner_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_DEPTH = 8;
	// indexes beyond the register map, writes there must be dropped
	localparam logic [ssc_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ssc_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] raw_sample;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] calibrated_value;
	logic signed [15:0] filtered_value;
	logic signed [15:0] min_value;
	logic signed [15:0] max_value;
	logic signed [15:0] smoothed_average;
	logic high_alarm;
	logic low_alarm;
	logic threshold_event;
	logic [31:0] samples_seen;
	logic [15:0] crossings_seen;
	logic cfg_valid;
	logic cfg_ready;
	logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data;

	sensor_sample_conditioner #(
		.FILTER_DEPTH(WINDOW_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.calibrated_value(calibrated_value),
		.filtered_value(filtered_value),
		.min_value(min_value),
		.max_value(max_value),
		.smoothed_average(smoothed_average),
		.high_alarm(high_alarm),
		.low_alarm(low_alarm),
		.threshold_event(threshold_event),
		.samples_seen(samples_seen),
		.crossings_seen(crossings_seen),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// register shadow
	ssc_pkg::sample_t cfg_offset = '0;
	logic [15:0] cfg_scale = 16'd256;
	ssc_pkg::sample_t cfg_high = '0;
	ssc_pkg::sample_t cfg_low = '0;
	logic [ssc_pkg::BAND_W-1:0] cfg_band = '0;
	logic [ssc_pkg::ENABLE_W-1:0] cfg_enable = '0;

	// conditioner state
	longint window[WINDOW_DEPTH];
	int win_slot = 0;
	int win_fill = 0;
	logic [ssc_pkg::COUNT_W-1:0] sample_total = '0;
	longint min_track = 0;
	longint max_track = 0;
	longint ema_acc = 0;
	bit high_latch = 1'b0;
	bit low_latch = 1'b0;
	logic [ssc_pkg::CROSS_W-1:0] crossing_total = '0;

	ssc_pkg::result_t expected_results[$];
	int failures = 0;
	bit steady_input = 1'b0;
	bit steady_output = 1'b0;
	int hold_off_cycles = 0;

	function automatic ssc_pkg::result_t condition_sample(input ssc_pkg::sample_t raw);
		ssc_pkg::result_t r;
		longint cal;
		longint filt;
		longint sum;
		bit first;
		bit evt;
		int i;
		// Q8.8 gain, signed division truncates toward zero
		cal = ((longint'(raw) + longint'(cfg_offset)) * longint'(cfg_scale)) / 256;
		if (cal > 32767)
			cal = 32767;
		if (cal < -32768)
			cal = -32768;
		filt = cal;
		if (cfg_enable[ssc_pkg::EN_FILTER]) begin
			window[win_slot] = cal;
			win_slot = (win_slot + 1) % WINDOW_DEPTH;
			if (win_fill < WINDOW_DEPTH)
				win_fill++;
			sum = 0;
			for (i = 0; i < win_fill; i++)
				sum += window[i];
			filt = sum / longint'(win_fill);
		end
		first = (sample_total == 0);
		if (sample_total != '1)
			sample_total++;
		if (first) begin
			min_track = cal;
			max_track = cal;
			ema_acc = cal * 256;
		end else begin
			if (cal < min_track)
				min_track = cal;
			if (cal > max_track)
				max_track = cal;
			ema_acc = (9 * ema_acc + 256 * cal) / 10;
		end
		evt = 1'b0;
		if (cfg_enable[ssc_pkg::EN_THRESH]) begin
			if (cfg_enable[ssc_pkg::EN_HIGH]) begin
				if (cal > longint'(cfg_high) + longint'(cfg_band)) begin
					if (!high_latch) begin
						high_latch = 1'b1;
						evt = 1'b1;
					end
				end else if (cal < longint'(cfg_high) - longint'(cfg_band)) begin
					high_latch = 1'b0;
				end
			end
			if (cfg_enable[ssc_pkg::EN_LOW]) begin
				if (cal < longint'(cfg_low) - longint'(cfg_band)) begin
					if (!low_latch) begin
						low_latch = 1'b1;
						evt = 1'b1;
					end
				end else if (cal > longint'(cfg_low) + longint'(cfg_band)) begin
					low_latch = 1'b0;
				end
			end
		end
		if (evt && crossing_total != '1)
			crossing_total++;
		r.calibrated = ssc_pkg::sample_t'(cal);
		r.filtered = ssc_pkg::sample_t'(filt);
		r.min_val = ssc_pkg::sample_t'(min_track);
		r.max_val = ssc_pkg::sample_t'(max_track);
		r.smoothed = ssc_pkg::sample_t'(ema_acc / 256);
		r.high_alarm = high_latch;
		r.low_alarm = low_latch;
		r.threshold_event = evt;
		r.samples = sample_total;
		r.crossings = crossing_total;
		return r;
	endfunction

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly lands around a threshold so the latches toggle
	function automatic ssc_pkg::sample_t random_raw();
		longint centre;
		longint spread;
		longint v;
		if ($urandom_range(0, 9) < 4)
			return ssc_pkg::sample_t'($urandom_range(0, 65535));
		centre = $urandom_range(0, 1) ? longint'(cfg_high) : longint'(cfg_low);
		spread = (cfg_band > 1000 ? 1000 : longint'(cfg_band)) + 64;
		v = centre - longint'(cfg_offset)
			+ longint'($urandom_range(0, int'(2 * spread))) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return ssc_pkg::sample_t'(v);
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		ssc_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no sample pending");
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("calibrated_value", want.calibrated, calibrated_value);
				check_field("filtered_value", want.filtered, filtered_value);
				check_field("min_value", want.min_val, min_value);
				check_field("max_value", want.max_val, max_value);
				check_field("smoothed_average", want.smoothed, smoothed_average);
				check_field("high_alarm", want.high_alarm, high_alarm);
				check_field("low_alarm", want.low_alarm, low_alarm);
				check_field("threshold_event", want.threshold_event, threshold_event);
				check_field("samples_seen", want.samples, samples_seen);
				check_field("crossings_seen", want.crossings, crossings_seen);
			end
		end
	end

	initial begin : output_side
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ready <= 1'b0;
			end else if (steady_output || stall_left == 0) begin
				out_ready <= 1'b1;
				if (!steady_output && $urandom_range(0, 3) == 0)
					stall_left = random_gap();
			end else begin
				stall_left--;
				out_ready <= 1'b0;
			end
		end
	end

	task automatic send_sample(input ssc_pkg::sample_t raw);
		int gap;
		gap = steady_input ? 0 : random_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		raw_sample <= raw;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(condition_sample(raw));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [ssc_pkg::CFG_INDEX_W-1:0] index,
			input logic [ssc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (index)
			ssc_pkg::REG_CAL_OFFSET: cfg_offset = data;
			ssc_pkg::REG_CAL_SCALE: cfg_scale = data;
			ssc_pkg::REG_HIGH_LIMIT: cfg_high = data;
			ssc_pkg::REG_LOW_LIMIT: cfg_low = data;
			ssc_pkg::REG_HYST_BAND: cfg_band = data[ssc_pkg::BAND_W-1:0];
			ssc_pkg::REG_ENABLE: cfg_enable = data[ssc_pkg::ENABLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic random_settings();
		logic [15:0] offset;
		logic [15:0] scale;
		logic [15:0] high;
		logic [15:0] low;
		logic [15:0] band;
		logic [15:0] enables;
		case ($urandom_range(0, 3))
			0: offset = 16'd0;
			1: offset = 16'($urandom_range(0, 400) - 200);
			2: offset = 16'($urandom);
			default: offset = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		endcase
		case ($urandom_range(0, 3))
			0: scale = 16'd256;
			1: scale = 16'($urandom_range(128, 512));
			2: scale = 16'($urandom);
			default: scale = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
		case ($urandom_range(0, 4))
			3: high = 16'($urandom);
			4: high = 16'h7FFF;
			default: high = 16'($urandom_range(0, 4000) - 2000);
		endcase
		case ($urandom_range(0, 4))
			3: low = 16'($urandom);
			4: low = 16'h8000;
			default: low = 16'($urandom_range(0, 4000) - 3000);
		endcase
		band = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
		// upper bits are don't-care for the enable register
		enables = 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			enables[ssc_pkg::EN_THRESH] = 1'b1;
		write_register(ssc_pkg::REG_CAL_OFFSET, offset);
		write_register(ssc_pkg::REG_CAL_SCALE, scale);
		write_register(ssc_pkg::REG_HIGH_LIMIT, high);
		write_register(ssc_pkg::REG_LOW_LIMIT, low);
		write_register(ssc_pkg::REG_HYST_BAND, band);
		write_register(ssc_pkg::REG_ENABLE, enables);
	endtask

	// first sample seeds min, max and the average
	task automatic test_power_up_defaults();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		drain_results();
	endtask

	task automatic test_calibration_edges();
		write_register(ssc_pkg::REG_CAL_OFFSET, 16'h7FFF);
		write_register(ssc_pkg::REG_CAL_SCALE, 16'hFFFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		drain_results();
		write_register(ssc_pkg::REG_CAL_OFFSET, 16'h8000);
		send_sample(16'sh8000);
		drain_results();
		// tiny negative product must truncate to zero, not -1
		write_register(ssc_pkg::REG_CAL_OFFSET, 16'h0000);
		write_register(ssc_pkg::REG_CAL_SCALE, 16'h0001);
		send_sample(-16'sd255);
		drain_results();
	endtask

	task automatic test_moving_average();
		write_register(ssc_pkg::REG_CAL_SCALE, 16'd256);
		write_register(ssc_pkg::REG_ENABLE, 16'h0001);
		send_sample(-16'sd7);
		send_sample(16'sd2);
		send_sample(-16'sd3);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd5);
		send_sample(-16'sd1);
		send_sample(16'sd100);
		send_sample(16'sd32000);
		drain_results();
		// window frozen while the filter is off
		write_register(ssc_pkg::REG_ENABLE, 16'h0000);
		send_sample(-16'sd50);
		drain_results();
	endtask

	task automatic test_alarm_hysteresis();
		write_register(ssc_pkg::REG_HIGH_LIMIT, 16'd100);
		write_register(ssc_pkg::REG_LOW_LIMIT, -16'sd100);
		write_register(ssc_pkg::REG_HYST_BAND, 16'd10);
		write_register(ssc_pkg::REG_ENABLE, 16'b1110);
		send_sample(16'sd111);
		send_sample(16'sd105);
		send_sample(16'sd89);
		send_sample(16'sd111);
		send_sample(-16'sd111);
		drain_results();
		write_register(ssc_pkg::REG_ENABLE, 16'b1100);
		send_sample(16'sd200);
		drain_results();
		write_register(ssc_pkg::REG_ENABLE, 16'b0110);
		send_sample(16'sd200);
		drain_results();
	endtask

	task automatic test_unused_register_index();
		write_register(REG_SPARE_LO, 16'hFFFF);
		write_register(REG_SPARE_HI, 16'h5A5A);
		send_sample(16'sd1234);
		drain_results();
	endtask

	// receiver holds off while samples keep coming, input must stall
	task automatic test_output_backpressure();
		write_register(ssc_pkg::REG_ENABLE, 16'h0001);
		steady_input = 1'b1;
		hold_off_cycles = 250;
		repeat (16) send_sample(random_raw());
		drain_results();
		steady_input = 1'b0;
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 12; phase++) begin
			random_settings();
			steady_input = (phase % 4 == 1);
			steady_output = (phase % 4 == 2);
			n = $urandom_range(25, 45);
			repeat (n) send_sample(random_raw());
			drain_results();
		end
		steady_input = 1'b0;
		steady_output = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_power_up_defaults();
		test_calibration_edges();
		test_moving_average();
		test_alarm_hysteresis();
		test_unused_register_index();
		test_output_backpressure();
		test_random_traffic();
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
